// File: rtl/digit_trie_prefix_detector_assert.svh
// ----------------------------------------------------------------------------
// Digit trie prefix detector: assertion macros
// Shared property forms for the clocked checks of the detector.
// ----------------------------------------------------------------------------
`ifndef DIGIT_TRIE_PREFIX_DETECTOR_ASSERT_SVH
`define DIGIT_TRIE_PREFIX_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtpd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DTPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtpd next-cycle check failed");

`endif

// File: rtl/dtpd_pkg.sv
// ----------------------------------------------------------------------------
// dtpd_pkg
// Sizes, command codes, sequencer states and node word layout of the
// digit trie prefix detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpd_pkg;

  localparam int NODE_POOL      = 16384;
  localparam int END_LIST_DEPTH = 4096;
  localparam int RADIX          = 10;

  localparam int CMD_W   = 2;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 13;

  localparam int NODE_W    = $clog2(NODE_POOL);
  localparam int LINK_DEPTH = NODE_POOL * RADIX;
  localparam int LINK_W    = $clog2(LINK_DEPTH);
  localparam int END_W     = $clog2(END_LIST_DEPTH);

  localparam logic [DIGIT_W:0]  RADIX_V     = (DIGIT_W + 1)'(RADIX);
  localparam logic [NODE_W:0]   NODE_POOL_V = (NODE_W + 1)'(NODE_POOL);
  localparam logic [END_W:0]    END_DEPTH_V = (END_W + 1)'(END_LIST_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_LINK,
    S_INS_NODE,
    S_Q_END,
    S_Q_NODE,
    S_Q_CHK,
    S_Q_OUT
  } state_t;

  // Each node keeps the link slot it was hung from, so a stale child
  // pointer left over from before a clear is recognized and ignored.
  typedef struct packed {
    logic [LINK_W-1:0]  parent;
    logic [COUNT_W-1:0] count;
  } node_t;

  localparam int NODE_WORD_W = $bits(node_t);

endpackage

`default_nettype wire

// File: rtl/dtpd_ram.sv
// ----------------------------------------------------------------------------
// dtpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/digit_trie_prefix_detector.sv
// ----------------------------------------------------------------------------
// digit_trie_prefix_detector
// Builds a digit trie from streamed strings and checks it for prefix
// conflicts on request.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the sequencer is
// idle. A clear, an unused command or an insert that is dropped completes in
// the idle state. A stored insert runs child link read, node read, then the
// node/link/end-list writes, since the child link RAM and the node RAM have
// registered reads. A query starts, then checks one end-list entry at a
// time (end list read, node read, count compare), and stops at the first
// conflict; the result is posted from S_Q_OUT, reached straight after a
// conflict and through S_Q_END once the list is exhausted, after any wait
// for an earlier result still held for out_ready. The result sits in an
// output register, so inserts and clears keep flowing while it waits for
// out_ready. A clear is instant: nodes are tagged with the link they hang
// from and only nodes below the free pointer count as live, so no RAM sweep
// is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digit_trie_prefix_detector_assert.svh"

module digit_trie_prefix_detector (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dtpd_pkg::CMD_W-1:0]   in_command,
  input  wire logic [dtpd_pkg::DIGIT_W-1:0] in_digit,
  input  wire logic                        in_last_digit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_prefix_found,
  output logic                             out_overflow
);

  dtpd_pkg::state_t state_r, state_nxt;

  logic [dtpd_pkg::NODE_W-1:0] walk_r, walk_nxt;
  logic [dtpd_pkg::NODE_W:0]   free_r, free_nxt;
  logic [dtpd_pkg::END_W:0]    end_total_r, end_total_nxt;
  logic [dtpd_pkg::END_W:0]    idx_r, idx_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [dtpd_pkg::LINK_W-1:0] link_r, link_nxt;
  logic [dtpd_pkg::NODE_W-1:0] child_r, child_nxt;
  logic                        last_r, last_nxt;
  logic                        found_r, found_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic out_ovf_r, out_ovf_nxt;

  // memory ports
  logic                             link_we;
  logic [dtpd_pkg::LINK_W-1:0]      link_waddr, link_raddr;
  logic [dtpd_pkg::NODE_W-1:0]      link_wdata, link_rdata;
  logic                             node_we;
  logic [dtpd_pkg::NODE_W-1:0]      node_waddr, node_raddr;
  dtpd_pkg::node_t                  node_wdata, node_rd;
  logic [dtpd_pkg::NODE_WORD_W-1:0] node_rdata;
  logic                             end_we;
  logic [dtpd_pkg::END_W-1:0]       end_waddr, end_raddr;
  logic [dtpd_pkg::NODE_W-1:0]      end_wdata, end_rdata;

  logic [dtpd_pkg::LINK_W-1:0]  link_calc;
  logic                         in_xfer;
  logic                         hit;
  logic [dtpd_pkg::NODE_W-1:0]  next_node;
  logic                         store_ok;

  assign in_ready  = (state_r == dtpd_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_prefix_found = out_found_r;
  assign out_overflow     = out_ovf_r;

  assign link_calc = dtpd_pkg::LINK_W'(walk_r) * dtpd_pkg::LINK_W'(dtpd_pkg::RADIX)
                   + dtpd_pkg::LINK_W'(in_digit);
  assign node_rd   = dtpd_pkg::node_t'(node_rdata);

  dtpd_ram #(.WIDTH(dtpd_pkg::NODE_W), .DEPTH(dtpd_pkg::LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  dtpd_ram #(.WIDTH(dtpd_pkg::NODE_WORD_W), .DEPTH(dtpd_pkg::NODE_POOL)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  dtpd_ram #(.WIDTH(dtpd_pkg::NODE_W), .DEPTH(dtpd_pkg::END_LIST_DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (end_wdata),
    .raddr (end_raddr),
    .rdata (end_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtpd_pkg::S_IDLE;
      walk_r      <= '0;
      free_r      <= (dtpd_pkg::NODE_W + 1)'(1);
      end_total_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      free_r      <= free_nxt;
      end_total_r <= end_total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    link_r      <= link_nxt;
    child_r     <= child_nxt;
    last_r      <= last_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    free_nxt      = free_r;
    end_total_nxt = end_total_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    link_nxt      = link_r;
    child_nxt     = child_r;
    last_nxt      = last_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;

    link_we    = 1'b0;
    link_waddr = link_r;
    link_wdata = '0;
    link_raddr = link_calc;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    end_we     = 1'b0;
    end_waddr  = end_total_r[dtpd_pkg::END_W-1:0];
    end_wdata  = '0;
    end_raddr  = idx_r[dtpd_pkg::END_W-1:0];
    hit        = 1'b0;
    next_node  = '0;
    store_ok   = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dtpd_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_command)
            dtpd_pkg::CMD_CLEAR: begin
              walk_nxt      = '0;
              free_nxt      = (dtpd_pkg::NODE_W + 1)'(1);
              end_total_nxt = '0;
              ovf_nxt       = 1'b0;
            end
            dtpd_pkg::CMD_INSERT: begin
              if (!ovf_r && ({1'b0, in_digit} < dtpd_pkg::RADIX_V)) begin
                if (in_last_digit && (end_total_r >= dtpd_pkg::END_DEPTH_V)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  link_nxt  = link_calc;
                  last_nxt  = in_last_digit;
                  state_nxt = dtpd_pkg::S_INS_LINK;
                end
              end
            end
            dtpd_pkg::CMD_QUERY: begin
              idx_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = dtpd_pkg::S_Q_END;
            end
            default: begin
            end
          endcase
        end
      end

      dtpd_pkg::S_INS_LINK: begin
        child_nxt  = link_rdata;
        node_raddr = link_rdata;
        state_nxt  = dtpd_pkg::S_INS_NODE;
      end

      dtpd_pkg::S_INS_NODE: begin
        // a live child: nonzero, allocated since the last clear, and hung here
        if ((child_r != '0) && ({1'b0, child_r} < free_r) && (node_rd.parent == link_r)) begin
          hit = 1'b1;
        end
        if (hit) begin
          next_node        = child_r;
          store_ok         = 1'b1;
          node_we          = 1'b1;
          node_waddr       = child_r;
          node_wdata.parent = link_r;
          node_wdata.count = (node_rd.count == dtpd_pkg::COUNT_MAX) ?
                             node_rd.count : node_rd.count + dtpd_pkg::COUNT_ONE;
        end else if (free_r >= dtpd_pkg::NODE_POOL_V) begin
          ovf_nxt = 1'b1;
        end else begin
          next_node         = free_r[dtpd_pkg::NODE_W-1:0];
          store_ok          = 1'b1;
          free_nxt          = free_r + (dtpd_pkg::NODE_W + 1)'(1);
          link_we           = 1'b1;
          link_wdata        = next_node;
          node_we           = 1'b1;
          node_waddr        = next_node;
          node_wdata.parent = link_r;
          node_wdata.count  = dtpd_pkg::COUNT_ONE;
        end
        if (store_ok) begin
          if (last_r) begin
            end_we        = 1'b1;
            end_wdata     = next_node;
            end_total_nxt = end_total_r + (dtpd_pkg::END_W + 1)'(1);
            walk_nxt      = '0;
          end else begin
            walk_nxt = next_node;
          end
        end
        state_nxt = dtpd_pkg::S_IDLE;
      end

      dtpd_pkg::S_Q_END: begin
        if (idx_r == end_total_r) begin
          state_nxt = dtpd_pkg::S_Q_OUT;
        end else begin
          state_nxt = dtpd_pkg::S_Q_NODE;
        end
      end

      dtpd_pkg::S_Q_NODE: begin
        node_raddr = end_rdata;
        state_nxt  = dtpd_pkg::S_Q_CHK;
      end

      dtpd_pkg::S_Q_CHK: begin
        if (node_rd.count != dtpd_pkg::COUNT_ONE) begin
          found_nxt = 1'b1;
          state_nxt = dtpd_pkg::S_Q_OUT;
        end else begin
          idx_nxt   = idx_r + (dtpd_pkg::END_W + 1)'(1);
          state_nxt = dtpd_pkg::S_Q_END;
        end
      end

      dtpd_pkg::S_Q_OUT: begin
        // hold until the previous result has been transferred
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = dtpd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dtpd_pkg::S_IDLE;
      end
    endcase
  end

  `DTPD_ASSERT_NOW(a_free_range, 1'b1, (free_r != '0) && (free_r <= dtpd_pkg::NODE_POOL_V))
  `DTPD_ASSERT_NOW(a_walk_live, 1'b1, ({1'b0, walk_r} < free_r))
  `DTPD_ASSERT_NEXT(a_end_hold, !in_xfer && !store_ok, $stable(end_total_r))
  `DTPD_ASSERT_NEXT(a_result_src, !out_valid_r && (state_r != dtpd_pkg::S_Q_OUT), !out_valid_r)

endmodule

`default_nettype wire
